// ----- src/hwor_pkg.sv -----
// hwor_pkg: shared widths, register map and reset values for the height
// window outlier reject block and its checker
// no dependencies
`default_nettype none

package hwor_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LIMIT_W-1:0]  limit_t;

  // register index, taken from byte address bit 2
  typedef enum logic {
    REG_STD_LIMIT = 1'b0,
    REG_DEV_LIMIT = 1'b1
  } reg_idx_t;

  localparam limit_t STD_LIMIT_RST = 16'd300;
  localparam limit_t DEV_LIMIT_RST = 16'd200;

endpackage

`default_nettype wire

// ----- src/height_window_outlier_reject.sv -----
// height_window_outlier_reject: sliding window of height samples, emits the
// oldest sample or zero when spread, distance or monotonic checks fail
// depends on hwor_pkg
`default_nettype none

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------
// in        | input     | in_valid / in_stall | in_height_sample [15:0]
// out       | output    | out_valid/out_stall | out_filtered_height [15:0]
// cfg (apb) | input     | psel/penable/pready | paddr [2:0], pwdata/prdata
//
// one sample beat per cycle is accepted while in_stall is low; the four oldest window
// samples are registered at the accepting edge and the checked value moves into the
// result register when the output is not stalled, with out_valid rising alongside
// the first DEPTH-1 beats after reset only fill the window and give no result
// synchronous active-low reset clears fill count and valid flags and loads the reset limits
// in_stall rises only when the input register holds a beat that the stalled
// output register cannot take

module height_window_outlier_reject #(
  parameter int DEPTH = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // sample channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [hwor_pkg::SAMPLE_W-1:0] in_height_sample,
  // result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [hwor_pkg::SAMPLE_W-1:0] out_filtered_height,
  // configuration port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [hwor_pkg::ADDR_W-1:0]   paddr,
  input  wire  [hwor_pkg::DATA_W-1:0]   pwdata,
  output logic [hwor_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int STORE = DEPTH - 1;      // samples held between beats
  localparam int CW    = $clog2(DEPTH);  // fill count holds 0..DEPTH-1
  localparam int SW    = hwor_pkg::SAMPLE_W;
  localparam int AW    = SW + 2;         // |4*x - sum| magnitude
  localparam int QW    = 2 * AW;         // one squared deviation
  localparam int TW    = QW + 2;         // four squares, also 64*std^2

  // squared reset limit
  localparam logic [31:0] STD_SQ_RST =
    32'(hwor_pkg::STD_LIMIT_RST) * 32'(hwor_pkg::STD_LIMIT_RST);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  hwor_pkg::limit_t   std_limit_r;
  hwor_pkg::limit_t   dev_limit_r;
  hwor_pkg::limit_t   std_limit_nxt;
  hwor_pkg::limit_t   dev_limit_nxt;
  hwor_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;
  logic [31:0]        std_sq_r;
  logic [TW-1:0]      lim;

  assign pready  = 1'b1;
  assign cfg_idx = hwor_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    std_limit_nxt = std_limit_r;
    dev_limit_nxt = dev_limit_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        hwor_pkg::REG_STD_LIMIT: std_limit_nxt = pwdata[hwor_pkg::LIMIT_W-1:0];
        hwor_pkg::REG_DEV_LIMIT: dev_limit_nxt = pwdata[hwor_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // squared limit follows the limit register at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_limit_r <= hwor_pkg::STD_LIMIT_RST;
      dev_limit_r <= hwor_pkg::DEV_LIMIT_RST;
      std_sq_r    <= STD_SQ_RST;
    end else begin
      std_limit_r <= std_limit_nxt;
      dev_limit_r <= dev_limit_nxt;
      std_sq_r    <= std_limit_nxt * std_limit_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hwor_pkg::REG_STD_LIMIT: prdata = {16'd0, std_limit_r};
      hwor_pkg::REG_DEV_LIMIT: prdata = {16'd0, dev_limit_r};
      default:                 prdata = '0;
    endcase
  end

  // spread test: sum of squared scaled deviations against 64*std^2
  assign lim = {std_sq_r, 6'd0};

  // ---------------------------------------------------------------------
  // readiness, backpressure from the output register
  // ---------------------------------------------------------------------
  logic v1_r, out_valid_r;
  logic rdy_out, rdy1;
  logic accept;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy1     = !v1_r || rdy_out;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  // ---------------------------------------------------------------------
  // sample window: DEPTH-1 stored samples plus the incoming one
  // ---------------------------------------------------------------------
  hwor_pkg::sample_t store_r [STORE];
  hwor_pkg::sample_t win     [DEPTH];
  logic [CW-1:0]     fill_r;
  logic              full;

  always_comb begin
    for (int i = 0; i < STORE; i++) begin
      win[i] = store_r[i];
    end
    win[DEPTH-1] = in_height_sample;
  end

  assign full = (fill_r == CW'(STORE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept && !full) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // filling appends at the fill slot, a full window shifts toward the oldest
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < STORE; i++) begin
        if (full) begin
          store_r[i] <= win[i+1];
        end else if (fill_r == CW'(i)) begin
          store_r[i] <= in_height_sample;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // input register: four oldest samples of the window
  // ---------------------------------------------------------------------
  hwor_pkg::sample_t x1_r [4];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 4; i++) begin
        x1_r[i] <= win[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // checks: scaled deviations, squares, distance and monotonic tests
  // ---------------------------------------------------------------------
  logic [AW-1:0]        sum4;
  logic signed [AW:0]   dev  [4];
  logic [AW-1:0]        adev [4];
  logic [QW-1:0]        sq   [4];
  logic [TW-1:0]        ss;
  logic                 mono, far, spread;
  hwor_pkg::sample_t    result;

  always_comb begin
    sum4 = AW'(x1_r[0]) + AW'(x1_r[1]) + AW'(x1_r[2]) + AW'(x1_r[3]);
    for (int i = 0; i < 4; i++) begin
      dev[i]  = $signed({1'b0, x1_r[i], 2'b00}) - $signed({1'b0, sum4});
      adev[i] = dev[i][AW] ? AW'(-dev[i]) : AW'(dev[i]);
      sq[i]   = adev[i] * adev[i];
    end
    ss     = TW'(sq[0]) + TW'(sq[1]) + TW'(sq[2]) + TW'(sq[3]);
    spread = ss > lim;
    // equal neighbours count as monotonic
    mono   = ((x1_r[0] <= x1_r[1]) && (x1_r[1] <= x1_r[2])) ||
             ((x1_r[0] >= x1_r[1]) && (x1_r[1] >= x1_r[2]));
    far    = adev[0] > {dev_limit_r, 2'b00};
    result = (!mono || far || spread) ? '0 : x1_r[0];
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  hwor_pkg::sample_t out_height_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_height_r <= result;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= accept && full;
      if (rdy_out) out_valid_r <= v1_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_height = out_height_r;

endmodule

`default_nettype wire

// ----- src/hwor_checker.sv -----
// hwor_checker: port-level assertions for the height window outlier reject
// block, bound to the top level below
// depends on hwor_pkg and height_window_outlier_reject
`default_nettype none

module hwor_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire [hwor_pkg::SAMPLE_W-1:0] in_height_sample,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [hwor_pkg::SAMPLE_W-1:0] out_filtered_height,
  input wire                          psel,
  input wire                          penable,
  input wire                          pwrite,
  input wire [hwor_pkg::ADDR_W-1:0]   paddr,
  input wire [hwor_pkg::DATA_W-1:0]   pwdata,
  input wire [hwor_pkg::DATA_W-1:0]   prdata,
  input wire                          pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_height))
    else $error("result beat changed while stalled");

  // input backs up only when the output itself is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a written limit reads back at once
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready ##1
     psel && !pwrite && paddr[2] == $past(paddr[2]))
    |-> prdata[hwor_pkg::LIMIT_W-1:0] == $past(pwdata[hwor_pkg::LIMIT_W-1:0]))
    else $error("limit register readback mismatch");

  // a stalled sample beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_height_sample))
    else $error("sample beat changed while stalled");

endmodule

bind height_window_outlier_reject hwor_checker u_hwor_checker (.*);

`default_nettype wire

// ----- bench/height_window_outlier_reject_tb.sv -----
// height_window_outlier_reject_tb: self-checking bench for the height window
// outlier reject block, with its own window predictor, random idling and apb writes
// depends on hwor_pkg and height_window_outlier_reject

module height_window_outlier_reject_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4;
  // two-register result path plus margin
  localparam int DRAIN_CYCLES = 12;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  hwor_pkg::sample_t           in_height_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  hwor_pkg::sample_t           out_filtered_height;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [hwor_pkg::ADDR_W-1:0] paddr = '0;
  logic [hwor_pkg::DATA_W-1:0] pwdata = '0;
  logic [hwor_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  height_window_outlier_reject #(
    .DEPTH(DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_height_sample    (in_height_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_height (out_filtered_height),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // samples waiting to be sent, and filtered heights the block still owes us
  hwor_pkg::sample_t heights_to_send[$];
  hwor_pkg::sample_t expected_heights[$];
  hwor_pkg::sample_t want_height;
  int      errors = 0;
  bit      in_beat = 1'b0;
  // no idling on either side while set
  bit      steady = 1'b0;

  // shadow of the block: sample window, fill level and both limits
  hwor_pkg::sample_t win [DEPTH];
  int                fill = 0;
  hwor_pkg::limit_t  std_lim = hwor_pkg::STD_LIMIT_RST;
  hwor_pkg::limit_t  dev_lim = hwor_pkg::DEV_LIMIT_RST;

  // random walk state for the sample generator
  int gen_level = 2000;
  int gen_trend = 1;
  int gen_step  = 50;

  // true when the oldest window sample has to be zeroed
  function automatic bit outlier_oldest();
    longint s, d0, d1, d2, d3, spread, bound, a0;
    bit up, down;
    s  = longint'(win[0]) + longint'(win[1]) + longint'(win[2]) + longint'(win[3]);
    // deviations scaled by four so the mean stays an integer
    d0 = 4 * longint'(win[0]) - s;
    d1 = 4 * longint'(win[1]) - s;
    d2 = 4 * longint'(win[2]) - s;
    d3 = 4 * longint'(win[3]) - s;
    spread = d0 * d0 + d1 * d1 + d2 * d2 + d3 * d3;
    // sixteen from the scaling times four samples
    bound = 64 * longint'(std_lim) * longint'(std_lim);
    a0 = (d0 < 0) ? -d0 : d0;
    // equal neighbours count as monotonic in both directions
    up   = (win[0] <= win[1]) && (win[1] <= win[2]);
    down = (win[0] >= win[1]) && (win[1] >= win[2]);
    if (spread > bound) return 1'b1;
    if (a0 > 4 * longint'(dev_lim)) return 1'b1;
    return !(up || down);
  endfunction

  // push one accepted sample into the shadow window, queue its result if any
  task automatic predict_height(input hwor_pkg::sample_t x);
    int i;
    if (fill < DEPTH) begin
      win[fill] = x;
      fill++;
    end
    if (fill == DEPTH) begin
      expected_heights.push_back(outlier_oldest() ? hwor_pkg::sample_t'(0) : win[0]);
      for (i = 0; i + 1 < DEPTH; i++) win[i] = win[i + 1];
      fill--;
    end
  endtask

  // sample side: a beat is offered at the falling edge and held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
      // stalled beat stays as it is
    end else if (heights_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 17)) begin
      in_valid         <= 1'b1;
      in_height_sample <= heights_to_send[0];
    end else begin
      in_valid         <= 1'b0;
      in_height_sample <= hwor_pkg::sample_t'($urandom);
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 17);
  end

  // both handshakes are sampled at the rising edge
  always @(posedge clk) begin
    in_beat = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_beat = 1'b1;
        predict_height(in_height_sample);
        void'(heights_to_send.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_heights.size() == 0) begin
          $error("filtered_height beat with nothing expected, actual %0d",
                 out_filtered_height);
          errors++;
        end else begin
          want_height = expected_heights.pop_front();
          if (out_filtered_height !== want_height) begin
            $error("filtered_height expected %0d actual %0d", want_height,
                   out_filtered_height);
            errors++;
          end
        end
      end
    end
  end

  // apb write: setup cycle, then access cycle until pready; upper bits are junk
  task automatic cfg_write(input hwor_pkg::reg_idx_t idx, input hwor_pkg::limit_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == hwor_pkg::REG_STD_LIMIT) std_lim = value;
    else dev_lim = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input hwor_pkg::limit_t std_v, input hwor_pkg::limit_t dev_v);
    cfg_write(hwor_pkg::REG_STD_LIMIT, std_v);
    cfg_write(hwor_pkg::REG_DEV_LIMIT, dev_v);
  endtask

  // block is idle once every sample is taken and every result has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (heights_to_send.size() != 0 || expected_heights.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly ramps and flat runs that get past the monotonic check, with spikes
  // and full-range noise mixed in
  task automatic queue_random(input int count);
    int k, mode, v;
    for (k = 0; k < count; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 5) begin
        gen_trend = -gen_trend;
        gen_step  = $urandom_range(0, 400);
      end
      if (mode < 70) begin
        gen_level += gen_trend * int'($urandom_range(0, gen_step));
        if (gen_level < 0) begin
          gen_level = 0;
          gen_trend = 1;
        end
        if (gen_level > 65535) begin
          gen_level = 65535;
          gen_trend = -1;
        end
        v = gen_level;
      end else if (mode < 80) begin
        v = gen_level;
      end else if (mode < 90) begin
        v = gen_level + int'($urandom_range(0, 2000)) - 1000;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end else begin
        v = $urandom_range(0, 65535);
        // sometimes move the walk so smooth data covers the whole range
        if (mode < 95) gen_level = v;
      end
      heights_to_send.push_back(hwor_pkg::sample_t'(v));
    end
  endtask

  initial begin
    int p, n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: distance right at the limit, then a ramp that passes,
    // then a zigzag that breaks monotonicity
    heights_to_send.push_back(16'd1000); heights_to_send.push_back(16'd800);
    heights_to_send.push_back(16'd700);  heights_to_send.push_back(16'd700);
    heights_to_send.push_back(16'd690);  heights_to_send.push_back(16'd500);
    heights_to_send.push_back(16'd510);  heights_to_send.push_back(16'd505);
    wait_idle();

    // spread and distance both exactly at their limits, then a distance reject
    set_limits(16'd100, 16'd100);
    heights_to_send.push_back(16'd200); heights_to_send.push_back(16'd200);
    heights_to_send.push_back(16'd0);   heights_to_send.push_back(16'd0);
    heights_to_send.push_back(16'd0);   heights_to_send.push_back(16'd0);
    wait_idle();

    // zero limits: only a window of equal samples passes
    set_limits(16'd0, 16'd0);
    repeat (5) heights_to_send.push_back(16'hffff);
    wait_idle();

    // widest limits with full-scale zigzags and steps
    set_limits(16'hffff, 16'hffff);
    heights_to_send.push_back(16'd0);     heights_to_send.push_back(16'hffff);
    heights_to_send.push_back(16'd0);     heights_to_send.push_back(16'hffff);
    heights_to_send.push_back(16'h8000);  heights_to_send.push_back(16'h5555);
    wait_idle();

    // random phases, each under its own limit setting
    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_limits(16'd300, 16'd200);
        1: set_limits(hwor_pkg::limit_t'($urandom_range(0, 300)),
                      hwor_pkg::limit_t'($urandom_range(0, 300)));
        2: set_limits(hwor_pkg::limit_t'($urandom), hwor_pkg::limit_t'($urandom));
        3: set_limits(16'd0, hwor_pkg::limit_t'($urandom_range(0, 2000)));
        4: set_limits(hwor_pkg::limit_t'($urandom_range(0, 2000)), 16'd0);
        5: set_limits(16'hffff, 16'hffff);
        6: set_limits(hwor_pkg::limit_t'($urandom_range(100, 1000)),
                      hwor_pkg::limit_t'($urandom_range(100, 1000)));
        default: set_limits(hwor_pkg::STD_LIMIT_RST, hwor_pkg::DEV_LIMIT_RST);
      endcase
      // one phase runs back to back with no idling
      steady = (p == 5);
      queue_random(215);
      if (p == 7) begin
        break;
      end
      wait_idle();
    end

    // drain with a bound, then let the pipeline settle
    for (n = 0; n < 20000 && (heights_to_send.size() != 0 || expected_heights.size() != 0);
         n++) begin
      @(negedge clk);
    end
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_heights.size() != 0) begin
      $error("filtered_height expected %0d actual none, %0d results missing",
             expected_heights[0], expected_heights.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- height_window_outlier_reject.f -----
src/hwor_pkg.sv
src/height_window_outlier_reject.sv
src/hwor_checker.sv
bench/height_window_outlier_reject_tb.sv
